// ----- design/mcar_pkg.sv -----
// ---------------------------------------------------------------------------
// mcar_pkg
// Shared types, sizes and the cordic arctangent table for the max-cut angle
// relaxation block.
// ---------------------------------------------------------------------------
`default_nettype none

package mcar_pkg;

  // graph and number formats
  localparam int MAX_NODES    = 64;
  localparam int NODE_W       = 6;
  localparam int CNT_W        = 7;
  localparam int ANGLE_BITS   = 16;
  localparam int SUM_BITS     = 24;
  localparam int TRIG_FRAC    = SUM_BITS - 11;
  localparam int TRIG_SH      = 30 - TRIG_FRAC;
  localparam int TRIG_W       = TRIG_FRAC + 3;
  localparam int DELTA_W      = TRIG_W + 1;
  localparam int WGT_W        = 4;
  localparam int PROD_W       = DELTA_W + WGT_W + 1;
  localparam int CUT_W        = 16;
  localparam int ADJ_AW       = 2 * NODE_W;

  // cordic datapath
  localparam int XY_W         = 44;
  localparam int Z_W          = 33;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 44'sd652032874;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS = 2'd2;

  // commands
  localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_LOAD_ANGLE  = 2'd1;
  localparam logic [1:0] CMD_RUN         = 2'd2;

  typedef enum logic {
    CM_ROTATE,
    CM_VECTOR
  } cmode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT_J,
    ST_INIT_RD,
    ST_INIT_CS,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_MOV_K,
    ST_MOV_RD,
    ST_MOV_VEC,
    ST_MOV_C0,
    ST_MOV_C1,
    ST_SWP_END,
    ST_CUT_K,
    ST_CUT_A,
    ST_CUT_I,
    ST_CUT_IM,
    ST_CUT_J,
    ST_CUT_JA,
    ST_DONE
  } st_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] turn_atan(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        5'd0:    v = 32'h20000000;
        5'd1:    v = 32'h12E4051E;
        5'd2:    v = 32'h09FB385B;
        5'd3:    v = 32'h051111D4;
        5'd4:    v = 32'h028B0D43;
        5'd5:    v = 32'h0145D7E1;
        5'd6:    v = 32'h00A2F61E;
        5'd7:    v = 32'h00517C55;
        5'd8:    v = 32'h0028BE53;
        5'd9:    v = 32'h00145F2F;
        5'd10:   v = 32'h000A2F98;
        5'd11:   v = 32'h000517CC;
        5'd12:   v = 32'h00028BE6;
        5'd13:   v = 32'h000145F3;
        5'd14:   v = 32'h0000A2F9;
        5'd15:   v = 32'h0000517D;
        5'd16:   v = 32'h000028BE;
        5'd17:   v = 32'h0000145F;
        5'd18:   v = 32'h00000A30;
        5'd19:   v = 32'h00000518;
        5'd20:   v = 32'h0000028C;
        5'd21:   v = 32'h00000146;
        5'd22:   v = 32'h000000A3;
        5'd23:   v = 32'h00000051;
        default: v = 32'h00000000;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/max_cut_angle_relaxation.sv -----
// ---------------------------------------------------------------------------
// max_cut_angle_relaxation
// Rank-two max-cut heuristic: loads digit weights and node angles, relaxes
// the angles by neighbour-sum sweeps and reports the best half-plane cut.
// ---------------------------------------------------------------------------
// Load words (weight or angle) are written while the block is idle. A run word
// occupies the block, all on one shared 24-step cordic unit and sum, angle and
// weight memories with one read and one write port each: it builds the sums
// node by node, relaxes the angles sweep by sweep, and then searches the cut
// over every node pair for each candidate half-plane.
// New words are stalled during a run; a finished result waits in the output
// register without blocking further loads.
`default_nettype none

module max_cut_angle_relaxation (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [mcar_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [mcar_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [1:0]                         in_cmd,
  input  wire  [5:0]                         in_row,
  input  wire  [5:0]                         in_col,
  input  wire  [3:0]                         in_weight,
  input  wire  [15:0]                        in_angle,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [14:0]                        out_best_cut,
  output logic [15:0]                        out_sweeps_done,
  output logic                               out_converged
);

  localparam int AB = mcar_pkg::ANGLE_BITS;
  localparam int SB = mcar_pkg::SUM_BITS;
  localparam int NW = mcar_pkg::NODE_W;
  localparam int CW = mcar_pkg::CNT_W;
  localparam int XW = mcar_pkg::XY_W;
  localparam int ZW = mcar_pkg::Z_W;
  localparam int TW = mcar_pkg::TRIG_W;
  localparam int DW = mcar_pkg::DELTA_W;
  localparam int PW = mcar_pkg::PROD_W;
  localparam int UW = mcar_pkg::CUT_W;
  localparam logic [AB-1:0]        HALF_TURN = AB'(1) << (AB - 1);
  localparam logic signed [XW-1:0] TRIG_HALF = XW'(1) << (mcar_pkg::TRIG_SH - 1);
  localparam logic [31:0]          ANG_HALF  = 32'd1 << (31 - AB);

  // configuration registers
  logic [6:0]  node_cnt_r;
  logic [11:0] eps_r;
  logic [15:0] maxsw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r <= 7'd64;
      eps_r      <= 12'd10;
      maxsw_r    <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcar_pkg::CFG_NODE_COUNT: node_cnt_r <= cfg_wdata[6:0];
        mcar_pkg::CFG_EPSILON:    eps_r      <= cfg_wdata[11:0];
        mcar_pkg::CFG_MAX_SWEEPS: maxsw_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  mcar_pkg::st_t st_r, st_nxt;
  logic [CW-1:0]        n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [15:0]          lim_r, lim_nxt, cnt_r, cnt_nxt;
  logic                 conv_r, conv_nxt, moving_r, moving_nxt;
  logic                 init_r, init_nxt, first_r, first_nxt, mark_i_r, mark_i_nxt;
  logic [AB-1:0]        old_r, old_nxt, new_r, new_nxt, a_r, a_nxt;
  logic [1:0]           q_r, q_nxt;
  logic signed [TW-1:0] c0_r, c0_nxt, s0_r, s0_nxt;
  logic signed [DW-1:0] dc_r, dc_nxt, ds_r, ds_nxt;
  logic [UW-1:0]        cut_r, cut_nxt, best_r, best_nxt;
  logic                 out_valid_r, out_valid_nxt, out_conv_r, out_conv_nxt;
  logic [14:0]          out_best_r, out_best_nxt;
  logic [15:0]          out_sw_r, out_sw_nxt;

  // memories
  logic [mcar_pkg::WGT_W-1:0] adj_mem_r [0:(1 << mcar_pkg::ADJ_AW)-1];
  logic [AB-1:0]              ang_mem_r [0:mcar_pkg::MAX_NODES-1];
  logic [SB-1:0]              cs_mem_r  [0:mcar_pkg::MAX_NODES-1];
  logic [SB-1:0]              sn_mem_r  [0:mcar_pkg::MAX_NODES-1];
  logic [mcar_pkg::WGT_W-1:0] adj_q_r;
  logic [AB-1:0]              ang_q_r;
  logic signed [SB-1:0]       cs_q_r, sn_q_r;

  logic                       adj_we, ang_we, sum_we;
  logic [mcar_pkg::ADJ_AW-1:0] adj_waddr, adj_raddr;
  logic [mcar_pkg::WGT_W-1:0] adj_wdata;
  logic [NW-1:0]              ang_waddr, ang_raddr, sum_waddr, sum_raddr;
  logic [AB-1:0]              ang_wdata;
  logic [SB-1:0]              cs_wdata, sn_wdata;

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem_r[adj_waddr] <= adj_wdata;
    adj_q_r <= adj_mem_r[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (ang_we) ang_mem_r[ang_waddr] <= ang_wdata;
    ang_q_r <= ang_mem_r[ang_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      cs_mem_r[sum_waddr] <= cs_wdata;
      sn_mem_r[sum_waddr] <= sn_wdata;
    end
    cs_q_r <= cs_mem_r[sum_raddr];
    sn_q_r <= sn_mem_r[sum_raddr];
  end

  // shared cordic
  logic                  cd_start, cd_done;
  mcar_pkg::cmode_t      cd_mode;
  logic signed [XW-1:0]  cd_x, cd_y, cd_xo, cd_yo;
  logic signed [ZW-1:0]  cd_z, cd_zo;

  mcar_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cd_start),
    .mode  (cd_mode),
    .x_in  (cd_x),
    .y_in  (cd_y),
    .z_in  (cd_z),
    .done  (cd_done),
    .x_out (cd_xo),
    .y_out (cd_yo),
    .z_out (cd_zo)
  );

  // cordic result post-processing: rounded cosine/sine and vector angle
  logic signed [XW-1:0] rx_full, ry_full;
  logic signed [TW-1:0] rx, ry, cos_v, sin_v;
  logic [31:0]          z_rnd;
  logic [AB-1:0]        nw_ang;

  always_comb begin
    rx_full = (cd_xo + TRIG_HALF) >>> mcar_pkg::TRIG_SH;
    ry_full = (cd_yo + TRIG_HALF) >>> mcar_pkg::TRIG_SH;
    rx      = rx_full[TW-1:0];
    ry      = ry_full[TW-1:0];
    case (q_r)
      2'd0:    begin cos_v = rx;  sin_v = ry;  end
      2'd1:    begin cos_v = -ry; sin_v = rx;  end
      2'd2:    begin cos_v = -rx; sin_v = -ry; end
      default: begin cos_v = ry;  sin_v = -rx; end
    endcase
    z_rnd  = cd_zo[31:0] + ANG_HALF;
    nw_ang = z_rnd[31 -: AB];
  end

  // rotation setup from an angle, vectoring setup from the current sums
  logic [AB-1:0]        rot_ang;
  logic [31:0]          rot_a32;
  logic signed [XW-1:0] vx, vy;
  logic [AB-1:0]        ang_dist, dist_raw;
  logic signed [DW-1:0] acc_dc, acc_ds;
  logic signed [PW-1:0] prod_c, prod_s;
  logic [SB-1:0]        base_c, base_s;
  logic [CW:0]          ip1;
  logic [16:0]          cnt_inc;

  function automatic logic in_half(input logic [AB-1:0] ang, input logic [AB-1:0] a);
    logic [AB:0] top;
    begin
      top = {1'b0, a} + {1'b0, HALF_TURN};
      return (ang >= a) && ({1'b0, ang} < top);
    end
  endfunction

  always_comb begin
    rot_a32 = {rot_ang, {(32 - AB){1'b0}}};
    vx      = -($signed({{(XW - SB){cs_q_r[SB-1]}}, cs_q_r}) <<< 16);
    vy      = -($signed({{(XW - SB){sn_q_r[SB-1]}}, sn_q_r}) <<< 16);
    dist_raw = new_nxt - old_r;
    ang_dist = (dist_raw > HALF_TURN) ? (~dist_raw + 1'b1) : dist_raw;
    acc_dc   = dc_r;
    acc_ds   = ds_r;
    prod_c   = acc_dc * $signed({1'b0, adj_q_r});
    prod_s   = acc_ds * $signed({1'b0, adj_q_r});
    base_c   = (init_r && first_r) ? '0 : cs_q_r;
    base_s   = (init_r && first_r) ? '0 : sn_q_r;
    ip1      = {1'b0, i_r} + 1'b1;
    cnt_inc  = {1'b0, cnt_r} + 1'b1;
  end

  // sequencer: next state, memory strobes and cordic starts
  always_comb begin
    st_nxt     = st_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    lim_nxt    = lim_r;
    cnt_nxt    = cnt_r;
    conv_nxt   = conv_r;
    moving_nxt = moving_r;
    init_nxt   = init_r;
    first_nxt  = first_r;
    mark_i_nxt = mark_i_r;
    old_nxt    = old_r;
    new_nxt    = new_r;
    a_nxt      = a_r;
    q_nxt      = q_r;
    c0_nxt     = c0_r;
    s0_nxt     = s0_r;
    dc_nxt     = dc_r;
    ds_nxt     = ds_r;
    cut_nxt    = cut_r;
    best_nxt   = best_r;
    out_best_nxt = out_best_r;
    out_sw_nxt   = out_sw_r;
    out_conv_nxt = out_conv_r;
    out_valid_nxt = out_valid_r && out_stall;

    in_stall  = (st_r != mcar_pkg::ST_IDLE);
    adj_we    = 1'b0;
    adj_waddr = {in_row, in_col};
    adj_wdata = in_weight;
    adj_raddr = {i_r[NW-1:0], j_r[NW-1:0]};
    ang_we    = 1'b0;
    ang_waddr = in_row;
    ang_wdata = in_angle[AB-1:0];
    ang_raddr = k_r[NW-1:0];
    sum_we    = 1'b0;
    sum_waddr = i_r[NW-1:0];
    sum_raddr = i_r[NW-1:0];
    cs_wdata  = base_c + {{(SB - PW){prod_c[PW-1]}}, prod_c};
    sn_wdata  = base_s + {{(SB - PW){prod_s[PW-1]}}, prod_s};
    cd_start  = 1'b0;
    cd_mode   = mcar_pkg::CM_ROTATE;
    rot_ang   = ang_q_r;
    cd_x      = mcar_pkg::CORDIC_GAIN;
    cd_y      = '0;
    cd_z      = $signed({3'b000, rot_a32[29:0]});

    unique case (st_r)
      mcar_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            mcar_pkg::CMD_LOAD_WEIGHT: adj_we = 1'b1;
            mcar_pkg::CMD_LOAD_ANGLE:  ang_we = 1'b1;
            mcar_pkg::CMD_RUN: begin
              n_nxt    = (node_cnt_r > CW'(mcar_pkg::MAX_NODES)) ?
                         CW'(mcar_pkg::MAX_NODES) : node_cnt_r;
              lim_nxt  = (maxsw_r == 16'd0) ? 16'd1 : maxsw_r;
              cnt_nxt  = '0;
              conv_nxt = 1'b0;
              j_nxt    = '0;
              st_nxt   = mcar_pkg::ST_INIT_J;
            end
            default: ;
          endcase
        end
      end

      // sum build: one column of weights per node angle
      mcar_pkg::ST_INIT_J: begin
        ang_raddr = j_r[NW-1:0];
        if (j_r == n_r) begin
          moving_nxt = 1'b0;
          k_nxt      = '0;
          st_nxt     = mcar_pkg::ST_MOV_K;
        end else begin
          st_nxt = mcar_pkg::ST_INIT_RD;
        end
      end
      mcar_pkg::ST_INIT_RD: begin
        cd_start = 1'b1;
        q_nxt    = rot_a32[31:30];
        st_nxt   = mcar_pkg::ST_INIT_CS;
      end
      mcar_pkg::ST_INIT_CS: begin
        if (cd_done) begin
          dc_nxt    = DW'(cos_v);
          ds_nxt    = DW'(sin_v);
          first_nxt = (j_r == '0);
          init_nxt  = 1'b1;
          i_nxt     = '0;
          st_nxt    = mcar_pkg::ST_ACC_RD;
        end
      end

      // shared sum update loop over all nodes
      mcar_pkg::ST_ACC_RD: begin
        adj_raddr = init_r ? {i_r[NW-1:0], j_r[NW-1:0]} : {k_r[NW-1:0], i_r[NW-1:0]};
        if (i_r == n_r) begin
          if (init_r) begin
            j_nxt  = j_r + 1'b1;
            st_nxt = mcar_pkg::ST_INIT_J;
          end else begin
            k_nxt  = k_r + 1'b1;
            st_nxt = mcar_pkg::ST_MOV_K;
          end
        end else begin
          st_nxt = mcar_pkg::ST_ACC_WR;
        end
      end
      mcar_pkg::ST_ACC_WR: begin
        sum_we = 1'b1;
        i_nxt  = i_r + 1'b1;
        st_nxt = mcar_pkg::ST_ACC_RD;
      end

      // node move
      mcar_pkg::ST_MOV_K: begin
        sum_raddr = k_r[NW-1:0];
        if (k_r == n_r) begin
          st_nxt = mcar_pkg::ST_SWP_END;
        end else begin
          st_nxt = mcar_pkg::ST_MOV_RD;
        end
      end
      mcar_pkg::ST_MOV_RD: begin
        old_nxt = ang_q_r;
        if (cs_q_r == '0 && sn_q_r == '0) begin
          k_nxt  = k_r + 1'b1;
          st_nxt = mcar_pkg::ST_MOV_K;
        end else begin
          cd_start = 1'b1;
          cd_mode  = mcar_pkg::CM_VECTOR;
          if (vx[XW-1]) begin
            cd_x = -vx;
            cd_y = -vy;
            cd_z = $signed({1'b0, 32'h80000000});
          end else begin
            cd_x = vx;
            cd_y = vy;
            cd_z = '0;
          end
          st_nxt = mcar_pkg::ST_MOV_VEC;
        end
      end
      mcar_pkg::ST_MOV_VEC: begin
        rot_ang = old_r;
        if (cd_done) begin
          new_nxt   = nw_ang;
          ang_we    = 1'b1;
          ang_waddr = k_r[NW-1:0];
          ang_wdata = nw_ang;
          cd_start  = 1'b1;
          q_nxt     = rot_a32[31:30];
          st_nxt    = mcar_pkg::ST_MOV_C0;
        end
      end
      mcar_pkg::ST_MOV_C0: begin
        rot_ang = new_r;
        if (cd_done) begin
          c0_nxt   = cos_v;
          s0_nxt   = sin_v;
          cd_start = 1'b1;
          q_nxt    = rot_a32[31:30];
          st_nxt   = mcar_pkg::ST_MOV_C1;
        end
      end
      mcar_pkg::ST_MOV_C1: begin
        if (cd_done) begin
          dc_nxt = DW'(cos_v) - DW'(c0_r);
          ds_nxt = DW'(sin_v) - DW'(s0_r);
          if ({{(AB - 12){1'b0}}, eps_r} < ang_dist) moving_nxt = 1'b1;
          init_nxt = 1'b0;
          i_nxt    = '0;
          st_nxt   = mcar_pkg::ST_ACC_RD;
        end
      end

      // end of a sweep
      mcar_pkg::ST_SWP_END: begin
        cnt_nxt = cnt_inc[15:0];
        k_nxt   = '0;
        if (!moving_r) begin
          conv_nxt = 1'b1;
          best_nxt = '0;
          st_nxt   = mcar_pkg::ST_CUT_K;
        end else if (cnt_inc >= {1'b0, lim_r}) begin
          best_nxt = '0;
          st_nxt   = mcar_pkg::ST_CUT_K;
        end else begin
          moving_nxt = 1'b0;
          st_nxt     = mcar_pkg::ST_MOV_K;
        end
      end

      // half-plane cut search
      mcar_pkg::ST_CUT_K: begin
        if (k_r == n_r) begin
          st_nxt = mcar_pkg::ST_DONE;
        end else begin
          st_nxt = mcar_pkg::ST_CUT_A;
        end
      end
      mcar_pkg::ST_CUT_A: begin
        a_nxt   = (ang_q_r > HALF_TURN) ? (ang_q_r - HALF_TURN) : ang_q_r;
        cut_nxt = '0;
        i_nxt   = '0;
        st_nxt  = mcar_pkg::ST_CUT_I;
      end
      mcar_pkg::ST_CUT_I: begin
        ang_raddr = i_r[NW-1:0];
        if (ip1 >= {1'b0, n_r}) begin
          if (cut_r > best_r) best_nxt = cut_r;
          k_nxt  = k_r + 1'b1;
          st_nxt = mcar_pkg::ST_CUT_K;
        end else begin
          st_nxt = mcar_pkg::ST_CUT_IM;
        end
      end
      mcar_pkg::ST_CUT_IM: begin
        mark_i_nxt = in_half(ang_q_r, a_r);
        j_nxt      = ip1[CW-1:0];
        st_nxt     = mcar_pkg::ST_CUT_J;
      end
      mcar_pkg::ST_CUT_J: begin
        ang_raddr = j_r[NW-1:0];
        if (j_r == n_r) begin
          i_nxt  = i_r + 1'b1;
          st_nxt = mcar_pkg::ST_CUT_I;
        end else begin
          st_nxt = mcar_pkg::ST_CUT_JA;
        end
      end
      mcar_pkg::ST_CUT_JA: begin
        if (in_half(ang_q_r, a_r) != mark_i_r)
          cut_nxt = cut_r + {{(UW - mcar_pkg::WGT_W){1'b0}}, adj_q_r};
        j_nxt  = j_r + 1'b1;
        st_nxt = mcar_pkg::ST_CUT_J;
      end

      // hand the result word to the output register
      mcar_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_best_nxt  = best_r[UW-1] ? 15'h7FFF : best_r[14:0];
          out_sw_nxt    = cnt_r;
          out_conv_nxt  = conv_r;
          st_nxt        = mcar_pkg::ST_IDLE;
        end
      end

      default: st_nxt = mcar_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mcar_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    lim_r      <= lim_nxt;
    cnt_r      <= cnt_nxt;
    conv_r     <= conv_nxt;
    moving_r   <= moving_nxt;
    init_r     <= init_nxt;
    first_r    <= first_nxt;
    mark_i_r   <= mark_i_nxt;
    old_r      <= old_nxt;
    new_r      <= new_nxt;
    a_r        <= a_nxt;
    q_r        <= q_nxt;
    c0_r       <= c0_nxt;
    s0_r       <= s0_nxt;
    dc_r       <= dc_nxt;
    ds_r       <= ds_nxt;
    cut_r      <= cut_nxt;
    best_r     <= best_nxt;
    out_best_r <= out_best_nxt;
    out_sw_r   <= out_sw_nxt;
    out_conv_r <= out_conv_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_best_cut    = out_best_r;
  assign out_sweeps_done = out_sw_r;
  assign out_converged   = out_conv_r;

endmodule

`default_nettype wire

// ----- design/mcar_cordic.sv -----
// ---------------------------------------------------------------------------
// mcar_cordic
// Shared iterative cordic unit, one micro-rotation per cycle. Rotation mode
// steers by the sign of z, vectoring mode by the sign of y.
// ---------------------------------------------------------------------------
`default_nettype none

module mcar_cordic (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  mcar_pkg::cmode_t                      mode,
  input  wire  logic signed [mcar_pkg::XY_W-1:0] x_in,
  input  wire  logic signed [mcar_pkg::XY_W-1:0] y_in,
  input  wire  logic signed [mcar_pkg::Z_W-1:0]  z_in,
  output logic                                  done,
  output logic signed [mcar_pkg::XY_W-1:0]       x_out,
  output logic signed [mcar_pkg::XY_W-1:0]       y_out,
  output logic signed [mcar_pkg::Z_W-1:0]        z_out
);

  logic signed [mcar_pkg::XY_W-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [mcar_pkg::Z_W-1:0]  z_r, z_nxt, at;
  logic [mcar_pkg::STEP_W-1:0]      step_r;
  logic                             run_r, done_r;
  mcar_pkg::cmode_t                 mode_r;
  logic                             down;

  // one micro-rotation
  always_comb begin
    xs   = x_r >>> step_r;
    ys   = y_r >>> step_r;
    at   = $signed({1'b0, mcar_pkg::turn_atan(step_r)});
    down = (mode_r == mcar_pkg::CM_ROTATE) ? !z_r[mcar_pkg::Z_W-1] : y_r[mcar_pkg::XY_W-1];
    if (down) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == mcar_pkg::STEP_W'(mcar_pkg::CORDIC_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x_in;
      y_r    <= y_in;
      z_r    <= z_in;
      mode_r <= mode;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

`default_nettype wire

// ----- test/tb_max_cut_angle_relaxation.sv -----
// ---------------------------------------------------------------------------
// tb_max_cut_angle_relaxation
// Self-checking bench for the max-cut angle relaxation block: loads weights
// and angles, issues run words under several register settings and checks
// each cut result against an in-bench cordic relaxation predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_max_cut_angle_relaxation;

  localparam int  WATCHDOG_LIMIT = 2000000;
  localparam int  HALF           = 32768;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [3:0]  weight;
    logic [15:0] angle;
  } word_t;

  typedef struct packed {
    logic [14:0] best_cut;
    logic [15:0] sweeps;
    logic        conv;
  } cut_t;

  // arctangent steps, 2^-32 turn units
  localparam longint ATAN_TURN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mcar_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mcar_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [5:0] in_row = '0;
  logic [5:0] in_col = '0;
  logic [3:0] in_weight = '0;
  logic [15:0] in_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] out_best_cut;
  logic [15:0] out_sweeps_done;
  logic out_converged;

  max_cut_angle_relaxation uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_row(in_row),
    .in_col(in_col), .in_weight(in_weight), .in_angle(in_angle),
    .out_valid(out_valid), .out_stall(out_stall), .out_best_cut(out_best_cut),
    .out_sweeps_done(out_sweeps_done), .out_converged(out_converged)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  word_t word_q[$];
  cut_t  cut_results_q[$];
  word_t cur_word;
  int    fail_cnt = 0;
  int    quiet_cnt = 0;
  bit    steady = 1'b0;

  // predictor state
  logic [3:0]  wt [mcar_pkg::MAX_NODES][mcar_pkg::MAX_NODES];
  logic [15:0] ang [mcar_pkg::MAX_NODES];
  bit          wt_known [mcar_pkg::MAX_NODES][mcar_pkg::MAX_NODES];
  bit          ang_known [mcar_pkg::MAX_NODES];
  longint      csum [mcar_pkg::MAX_NODES];
  longint      ssum [mcar_pkg::MAX_NODES];
  int          node_cnt = 64;
  int          eps_cfg = 10;
  int          sweep_cap = 1000;

  function automatic longint wrap24(input longint v);
    logic signed [23:0] w;
    w = v[23:0];
    return w;
  endfunction

  // rotation cordic, quadrant folded, rounded to trig fraction bits
  function automatic void trig(input logic [15:0] a16, output longint c, output longint s);
    logic [31:0] a;
    longint x, y, z, nx, ny, rx, ry;
    a = {a16, 16'h0};
    z = longint'(a[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_TURN[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_TURN[i];
      end
      x = nx; y = ny;
    end
    rx = (x + (64'sd1 <<< 16)) >>> 17;
    ry = (y + (64'sd1 <<< 16)) >>> 17;
    case (a[31:30])
      2'd0: begin c = rx; s = ry; end
      2'd1: begin c = -ry; s = rx; end
      2'd2: begin c = -rx; s = -ry; end
      default: begin c = ry; s = -rx; end
    endcase
  endfunction

  // vectoring cordic: direction of (x, y) in angle units
  function automatic logic [15:0] heading(input longint xi, input longint yi);
    logic [31:0] z;
    longint x, y, nx, ny;
    x = xi * 65536;
    y = yi * 65536;
    z = 32'h0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < 24; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_TURN[i][31:0];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_TURN[i][31:0];
      end
      x = nx; y = ny;
    end
    z += 32'h8000;
    return z[31:16];
  endfunction

  // full relaxation and cut search for one run word
  function automatic cut_t relax_and_cut();
    int n, lim, cnt, best, cut, a, d;
    longint c, s, c0, s0;
    logic [15:0] old_a, new_a;
    bit moving;
    bit side [mcar_pkg::MAX_NODES];
    cut_t r;
    n = (node_cnt > mcar_pkg::MAX_NODES) ? mcar_pkg::MAX_NODES : node_cnt;
    lim = (sweep_cap == 0) ? 1 : sweep_cap;
    cnt = 0;
    best = 0;
    for (int i = 0; i < n; i++) begin
      csum[i] = 0; ssum[i] = 0;
    end
    for (int j = 0; j < n; j++) begin
      trig(ang[j], c, s);
      for (int i = 0; i < n; i++) begin
        csum[i] = wrap24(csum[i] + c * wt[i][j]);
        ssum[i] = wrap24(ssum[i] + s * wt[i][j]);
      end
    end
    r.conv = 1'b0;
    forever begin
      moving = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (csum[k] == 0 && ssum[k] == 0) continue;
        old_a = ang[k];
        new_a = heading(-csum[k], -ssum[k]);
        ang[k] = new_a;
        trig(old_a, c0, s0);
        trig(new_a, c, s);
        for (int i = 0; i < n; i++) begin
          csum[i] = wrap24(csum[i] + (c - c0) * wt[k][i]);
          ssum[i] = wrap24(ssum[i] + (s - s0) * wt[k][i]);
        end
        d = int'(16'(new_a - old_a));
        if (d > HALF) d = 65536 - d;
        if (d > eps_cfg) moving = 1'b1;
      end
      cnt++;
      if (!moving) begin
        r.conv = 1'b1;
        break;
      end
      if (cnt >= lim) break;
    end
    r.sweeps = cnt[15:0];
    for (int k = 0; k < n; k++) begin
      a = (ang[k] > HALF) ? int'(ang[k]) - HALF : int'(ang[k]);
      cut = 0;
      for (int j = 0; j < n; j++) side[j] = (ang[j] >= a) && (int'(ang[j]) < a + HALF);
      for (int i = 0; i + 1 < n; i++)
        for (int j = i + 1; j < n; j++)
          if (side[i] != side[j]) cut += wt[i][j];
      if (cut > best) best = cut;
    end
    r.best_cut = (best > 32767) ? 15'h7FFF : best[14:0];
    return r;
  endfunction

  function automatic void apply_word(input word_t w);
    case (w.cmd)
      mcar_pkg::CMD_LOAD_WEIGHT: wt[w.row][w.col] = w.weight;
      mcar_pkg::CMD_LOAD_ANGLE:  ang[w.row] = w.angle;
      mcar_pkg::CMD_RUN:         cut_results_q.push_back(relax_and_cut());
      default: ;
    endcase
  endfunction

  // driver: present pending words, with random gaps outside steady phases
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) apply_word(cur_word);
      if (word_q.size() > 0 && (steady || $urandom_range(99) >= 30)) begin
        cur_word = word_q.pop_front();
        in_valid <= 1'b1;
        in_cmd <= cur_word.cmd;
        in_row <= cur_word.row;
        in_col <= cur_word.col;
        in_weight <= cur_word.weight;
        in_angle <= cur_word.angle;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check results, random output stall outside steady phases, watchdog
  always @(posedge clk) begin
    cut_t e;
    if (rst_n) begin
      out_stall <= !steady && ($urandom_range(99) < 30);
      if (out_valid && !out_stall) begin
        if (cut_results_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          e = cut_results_q.pop_front();
          if (out_best_cut !== e.best_cut) begin
            $error("best_cut expected %0d actual %0d", e.best_cut, out_best_cut);
            fail_cnt++;
          end
          if (out_sweeps_done !== e.sweeps) begin
            $error("sweeps_done expected %0d actual %0d", e.sweeps, out_sweeps_done);
            fail_cnt++;
          end
          if (out_converged !== e.conv) begin
            $error("converged expected %0d actual %0d", e.conv, out_converged);
            fail_cnt++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cnt <= 0;
      else quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [1:0] cmd, input int r, input int c,
                           input int w, input int a);
    word_t x;
    x.cmd = cmd; x.row = r[5:0]; x.col = c[5:0]; x.weight = w[3:0]; x.angle = a[15:0];
    if (cmd == mcar_pkg::CMD_LOAD_WEIGHT) wt_known[r][c] = 1'b1;
    if (cmd == mcar_pkg::CMD_LOAD_ANGLE) ang_known[r] = 1'b1;
    word_q.push_back(x);
  endtask

  // wait until every word is taken and every result is back, then settle
  task automatic drain();
    @(negedge clk);
    while (word_q.size() != 0 || in_valid || cut_results_q.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(input int nc, input int ep, input int ms);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= mcar_pkg::CFG_NODE_COUNT; cfg_wdata <= nc[15:0];
    @(posedge clk);
    cfg_index <= mcar_pkg::CFG_EPSILON; cfg_wdata <= ep[15:0];
    @(posedge clk);
    cfg_index <= mcar_pkg::CFG_MAX_SWEEPS; cfg_wdata <= ms[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    node_cnt = nc & 8'h7F;
    eps_cfg = ep & 12'hFFF;
    sweep_cap = ms & 16'hFFFF;
  endtask

  function automatic int rand_weight();
    return ($urandom_range(9) == 0) ? $urandom_range(15, 10) : $urandom_range(9);
  endfunction

  // load every weight and angle a run with n nodes reads but that is unset
  task automatic fill_missing(input int n, input bit zero_w);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++)
        if (!wt_known[i][j] || zero_w)
          push_word(mcar_pkg::CMD_LOAD_WEIGHT, i, j, zero_w ? 0 : rand_weight(), 0);
      if (!ang_known[i]) push_word(mcar_pkg::CMD_LOAD_ANGLE, i, 0, 0, $urandom_range(65535));
    end
  endtask

  task automatic noise_words(input int cnt);
    for (int k = 0; k < cnt; k++)
      case ($urandom_range(3))
        0: push_word(mcar_pkg::CMD_LOAD_WEIGHT, $urandom_range(63), $urandom_range(63),
                     rand_weight(), $urandom_range(65535));
        1: push_word(mcar_pkg::CMD_LOAD_ANGLE, $urandom_range(63), $urandom_range(63),
                     $urandom_range(15), $urandom_range(65535));
        2: push_word(CMD_NONE, $urandom_range(63), $urandom_range(63),
                     $urandom_range(15), $urandom_range(65535));
        default: push_word(mcar_pkg::CMD_LOAD_ANGLE, $urandom_range(7), 0, 0,
                           $urandom_range(65535));
      endcase
  endtask

  initial begin
    int n;
    for (int i = 0; i < mcar_pkg::MAX_NODES; i++) begin
      ang_known[i] = 1'b0;
      for (int j = 0; j < mcar_pkg::MAX_NODES; j++) wt_known[i][j] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // two nodes, field extremes, zero epsilon and zero sweep limit
    set_regs(2, 0, 0);
    push_word(mcar_pkg::CMD_LOAD_WEIGHT, 0, 0, 0, 0);
    push_word(mcar_pkg::CMD_LOAD_WEIGHT, 0, 1, 15, 65535);
    push_word(mcar_pkg::CMD_LOAD_WEIGHT, 1, 0, 9, 0);
    push_word(mcar_pkg::CMD_LOAD_WEIGHT, 1, 1, 0, 0);
    push_word(mcar_pkg::CMD_LOAD_ANGLE, 0, 63, 15, 0);
    push_word(mcar_pkg::CMD_LOAD_ANGLE, 1, 0, 0, 65535);
    push_word(CMD_NONE, 63, 63, 15, 65535);
    push_word(mcar_pkg::CMD_RUN, 0, 0, 0, 0);
    push_word(mcar_pkg::CMD_LOAD_WEIGHT, 63, 63, 15, 0);
    push_word(mcar_pkg::CMD_RUN, 63, 63, 15, 65535);

    // empty graphs: no nodes and one node
    set_regs(0, 10, 5);
    push_word(mcar_pkg::CMD_RUN, 0, 0, 0, 0);
    set_regs(1, 10, 5);
    push_word(mcar_pkg::CMD_RUN, 0, 0, 0, 0);

    // all-zero weights: zero neighbour vectors, widest epsilon and sweep limit
    set_regs(3, 4095, 65535);
    fill_missing(3, 1'b1);
    push_word(mcar_pkg::CMD_RUN, 0, 0, 0, 0);

    // random phases on small graphs
    for (int p = 0; p < 40; p++) begin
      n = ($urandom_range(4) == 0) ? $urandom_range(1, 0) : $urandom_range(7, 2);
      set_regs(n, ($urandom_range(4) == 0) ? 4095 : $urandom_range(400),
               ($urandom_range(5) == 0) ? 0 : $urandom_range(6, 1));
      steady = (p % 8 == 5);
      fill_missing(n, 1'b0);
      noise_words($urandom_range(6));
      push_word(mcar_pkg::CMD_RUN, $urandom_range(63), $urandom_range(63),
                $urandom_range(15), $urandom_range(65535));
      if ($urandom_range(1)) begin
        noise_words($urandom_range(8, 1));
        push_word(mcar_pkg::CMD_RUN, 0, 0, 0, 0);
      end
    end
    steady = 1'b0;

    // mid-size graph, one sweep
    set_regs(16, 0, 1);
    fill_missing(16, 1'b0);
    push_word(mcar_pkg::CMD_RUN, 0, 0, 0, 0);

    drain();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
